// File: hw/rtl/dmpd_pkg.sv
package dmpd_pkg;

   // Counter and on-time width
   localparam int COUNT_WIDTH = 20;
   // Product of period and duty before the divide by 255
   localparam int PROD_W = COUNT_WIDTH + 8;
   // Step counter: holds PROD_W - 1 and 15
   localparam int STEP_W = $clog2(PROD_W);

   localparam int SPEED_W = 16;
   localparam int DUTY_W = 8;
   localparam int ACC_W = 31;   // Q1.30 effective fraction, up to 2^30
   localparam int CSR_W = 20;

   localparam logic [SPEED_W-1:0] Q_ONE = 16'd32768;
   localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;
   localparam logic [DUTY_W:0] DIVISOR = 9'd255;

   // Transaction opcodes
   localparam logic [2:0] OP_TICK    = 3'd0;
   localparam logic [2:0] OP_SET_A   = 3'd1;
   localparam logic [2:0] OP_SET_B   = 3'd2;
   localparam logic [2:0] OP_SET_AB  = 3'd3;
   localparam logic [2:0] OP_STANDBY = 3'd4;

   // Register indexes
   localparam logic [1:0] REG_PERIOD   = 2'd0;
   localparam logic [1:0] REG_MIN_FRAC = 2'd1;
   localparam logic [1:0] REG_DEADBAND = 2'd2;

   // Direction pins: IN1 in bit 1, IN2 in bit 0
   localparam logic [1:0] DIR_COAST = 2'b00;
   localparam logic [1:0] DIR_REV   = 2'b01;
   localparam logic [1:0] DIR_FWD   = 2'b10;

   typedef struct packed {
      logic start;
      logic load;
   } lane_cmd_type;

   typedef struct packed {
      logic                   busy;
      logic [1:0]             dir;
      logic [DUTY_W-1:0]      duty;
      logic [COUNT_WIDTH-1:0] on_ticks;
   } lane_stat_type;

endpackage

// File: hw/rtl/dmpd_lane.sv
module dmpd_lane import dmpd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  lane_cmd_type              cmd,
   input  logic signed [SPEED_W-1:0] speed,
   input  logic [SPEED_W-1:0]        min_fraction,
   input  logic [SPEED_W-1:0]        deadband,
   input  logic [COUNT_WIDTH-1:0]    period,
   output lane_stat_type             stat
);

   typedef enum logic [2:0] {
      L_IDLE,
      L_DUTY,
      L_SCALE,
      L_CLAMP,
      L_MUL,
      L_DIV
   } lane_state_type;

   lane_state_type         state_ff, state_in;
   logic [1:0]             dir_ff, dir_in;
   logic [DUTY_W-1:0]      duty_ff, duty_in;
   logic [COUNT_WIDTH-1:0] on_ff, on_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [SPEED_W-1:0]     mplr_ff, mplr_in;
   logic [DUTY_W-1:0]      dsh_ff, dsh_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [DUTY_W-1:0]      rem_ff, rem_in;
   logic [STEP_W-1:0]      step_ff, step_in;

   logic [SPEED_W-1:0]     mf_sat, db_sat, mcand, mag;
   logic                   neg;
   logic [ACC_W+7:0]       scaled;
   logic [DUTY_W:0]        duty_raw;
   logic [DUTY_W:0]        shifted;
   logic                   qbit;

   // Saturated fractions and command magnitude
   assign mf_sat = (min_fraction > Q_ONE) ? Q_ONE : min_fraction;
   assign db_sat = (deadband > Q_ONE) ? Q_ONE : deadband;
   assign mcand  = Q_ONE - mf_sat;
   assign neg    = speed[SPEED_W-1];
   assign mag    = neg ? (~speed + 16'd1) : speed;

   // duty = (eff * 255) >> 30
   assign scaled   = {acc_ff, 8'b0} - {8'b0, acc_ff};
   assign duty_raw = scaled[ACC_W+7:ACC_W-1];

   // Restoring divide by 255, one quotient bit per cycle
   assign shifted = {rem_ff, prod_ff[PROD_W-1]};
   assign qbit    = (shifted >= DIVISOR);

   always_comb begin
      state_in = state_ff;
      dir_in   = dir_ff;
      duty_in  = duty_ff;
      on_in    = on_ff;
      acc_in   = acc_ff;
      mplr_in  = mplr_ff;
      dsh_in   = dsh_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      case (state_ff)
         L_IDLE: begin
            if (cmd.start) begin
               prod_in  = '0;
               dsh_in   = duty_ff;
               step_in  = STEP_W'(DUTY_W - 1);
               state_in = L_MUL;
               if (cmd.load) begin
                  if (mag == '0 || mag < db_sat) begin
                     dir_in  = DIR_COAST;
                     duty_in = '0;
                     dsh_in  = '0;
                  end else begin
                     dir_in   = neg ? DIR_REV : DIR_FWD;
                     acc_in   = '0;
                     mplr_in  = mag;
                     step_in  = STEP_W'(SPEED_W - 1);
                     state_in = L_DUTY;
                  end
               end
            end
         end
         // (Q_ONE - mf) * mag, multiplier MSB first
         L_DUTY: begin
            acc_in  = {acc_ff[ACC_W-2:0], 1'b0} +
                      (mplr_ff[SPEED_W-1] ? {15'b0, mcand} : '0);
            mplr_in = {mplr_ff[SPEED_W-2:0], 1'b0};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = L_SCALE;
            end
         end
         L_SCALE: begin
            acc_in   = acc_ff + {mf_sat, 15'b0};
            state_in = L_CLAMP;
         end
         L_CLAMP: begin
            duty_in  = (duty_raw > {1'b0, DUTY_MAX}) ? DUTY_MAX : duty_raw[DUTY_W-1:0];
            dsh_in   = duty_in;
            prod_in  = '0;
            step_in  = STEP_W'(DUTY_W - 1);
            state_in = L_MUL;
         end
         // period * duty, duty bits MSB first
         L_MUL: begin
            prod_in = {prod_ff[PROD_W-2:0], 1'b0} +
                      (dsh_ff[DUTY_W-1] ? {8'b0, period} : '0);
            dsh_in  = {dsh_ff[DUTY_W-2:0], 1'b0};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               rem_in   = '0;
               step_in  = STEP_W'(PROD_W - 1);
               state_in = L_DIV;
            end
         end
         L_DIV: begin
            rem_in  = qbit ? DUTY_W'(shifted - DIVISOR) : shifted[DUTY_W-1:0];
            prod_in = {prod_ff[PROD_W-2:0], qbit};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               on_in    = prod_in[COUNT_WIDTH-1:0];
               state_in = L_IDLE;
            end
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         dir_ff   <= DIR_COAST;
         duty_ff  <= '0;
         on_ff    <= '0;
      end else begin
         state_ff <= state_in;
         dir_ff   <= dir_in;
         duty_ff  <= duty_in;
         on_ff    <= on_in;
      end
      acc_ff  <= acc_in;
      mplr_ff <= mplr_in;
      dsh_ff  <= dsh_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   assign stat.busy     = (state_ff != L_IDLE);
   assign stat.dir      = dir_ff;
   assign stat.duty     = duty_ff;
   assign stat.on_ticks = on_ff;

endmodule

// File: hw/rtl/dual_motor_pwm_drive_core.sv
// Each transaction waits for both lanes; a lane loaded with a speed first runs a 16-step
// serial multiply, scale and clamp, which a tick, standby or unused transaction skips.
// Both lanes recompute on-time every transaction: 8 multiply steps, then
// COUNT_WIDTH + 8 divide-by-255 steps; one transaction is in flight at a time.
// The next transaction is taken once the result is registered, also while rsp waits.
// Synchronous reset: period 1000, duties, on-times, counter and STBY zero, coast.
module dual_motor_pwm_drive_core import dmpd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_opcode,
   input  logic signed [SPEED_W-1:0] req_speed_a,
   input  logic signed [SPEED_W-1:0] req_speed_b,
   input  logic                      req_standby_enable,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_a_in1,
   output logic                      rsp_a_in2,
   output logic                      rsp_a_pwm,
   output logic                      rsp_b_in1,
   output logic                      rsp_b_in2,
   output logic                      rsp_b_pwm,
   output logic                      rsp_standby_pin,
   output logic [DUTY_W-1:0]         rsp_duty_a_out,
   output logic [DUTY_W-1:0]         rsp_duty_b_out,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [CSR_W-1:0]          csr_wdata
);

   typedef enum logic [1:0] {
      T_IDLE,
      T_BUSY,
      T_OUT
   } top_state_type;

   top_state_type          state_ff, state_in;
   logic [COUNT_WIDTH-1:0] period_ff, period_in;
   logic [SPEED_W-1:0]     minfrac_ff, minfrac_in;
   logic [SPEED_W-1:0]     deadband_ff, deadband_in;
   logic [COUNT_WIDTH-1:0] counter_ff, counter_in;
   logic                   standby_ff, standby_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             a_dir_ff, a_dir_in, b_dir_ff, b_dir_in;
   logic                   a_pwm_ff, a_pwm_in, b_pwm_ff, b_pwm_in;
   logic [DUTY_W-1:0]      a_duty_ff, a_duty_in, b_duty_ff, b_duty_in;
   logic                   stby_out_ff, stby_out_in;

   logic                   accept;
   logic [COUNT_WIDTH-1:0] period_eff;
   logic [COUNT_WIDTH-1:0] count_next;
   lane_cmd_type           cmd_a, cmd_b;
   lane_stat_type          stat_a, stat_b;

   assign accept     = req_valid && req_ready;
   assign req_ready  = (state_ff == T_IDLE);
   assign period_eff = (period_ff == '0) ? COUNT_WIDTH'(1) : period_ff;
   assign count_next = counter_ff + 1'b1;

   // Lane start and speed load
   assign cmd_a.start = accept;
   assign cmd_a.load  = req_opcode inside {OP_SET_A, OP_SET_AB};
   assign cmd_b.start = accept;
   assign cmd_b.load  = req_opcode inside {OP_SET_B, OP_SET_AB};

   dmpd_lane u_lane_a (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd_a),
      .speed        (req_speed_a),
      .min_fraction (minfrac_ff),
      .deadband     (deadband_ff),
      .period       (period_eff),
      .stat         (stat_a)
   );

   dmpd_lane u_lane_b (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd_b),
      .speed        (req_speed_b),
      .min_fraction (minfrac_ff),
      .deadband     (deadband_ff),
      .period       (period_eff),
      .stat         (stat_b)
   );

   // Configuration writes
   always_comb begin
      period_in   = period_ff;
      minfrac_in  = minfrac_ff;
      deadband_in = deadband_ff;
      if (csr_we) begin
         case (csr_index)
            REG_PERIOD:   period_in   = csr_wdata[COUNT_WIDTH-1:0];
            REG_MIN_FRAC: minfrac_in  = csr_wdata[SPEED_W-1:0];
            REG_DEADBAND: deadband_in = csr_wdata[SPEED_W-1:0];
            default:      ;
         endcase
      end
   end

   // Transaction control, counter, standby and result register
   always_comb begin
      state_in     = state_ff;
      counter_in   = counter_ff;
      standby_in   = standby_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      a_dir_in     = a_dir_ff;
      b_dir_in     = b_dir_ff;
      a_pwm_in     = a_pwm_ff;
      b_pwm_in     = b_pwm_ff;
      a_duty_in    = a_duty_ff;
      b_duty_in    = b_duty_ff;
      stby_out_in  = stby_out_ff;
      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_TICK:    counter_in = (count_next >= period_eff) ? '0 : count_next;
                  OP_STANDBY: standby_in = req_standby_enable;
                  default:    ;
               endcase
               state_in = T_BUSY;
            end
         end
         T_BUSY: begin
            if (!stat_a.busy && !stat_b.busy) begin
               state_in = T_OUT;
            end
         end
         T_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               a_dir_in     = stat_a.dir;
               b_dir_in     = stat_b.dir;
               a_pwm_in     = (counter_ff < stat_a.on_ticks);
               b_pwm_in     = (counter_ff < stat_b.on_ticks);
               a_duty_in    = stat_a.duty;
               b_duty_in    = stat_b.duty;
               stby_out_in  = standby_ff;
               state_in     = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         period_ff    <= COUNT_WIDTH'(1000);
         minfrac_ff   <= '0;
         deadband_ff  <= '0;
         counter_ff   <= '0;
         standby_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         minfrac_ff   <= minfrac_in;
         deadband_ff  <= deadband_in;
         counter_ff   <= counter_in;
         standby_ff   <= standby_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_dir_ff    <= a_dir_in;
      b_dir_ff    <= b_dir_in;
      a_pwm_ff    <= a_pwm_in;
      b_pwm_ff    <= b_pwm_in;
      a_duty_ff   <= a_duty_in;
      b_duty_ff   <= b_duty_in;
      stby_out_ff <= stby_out_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_a_in1       = a_dir_ff[1];
   assign rsp_a_in2       = a_dir_ff[0];
   assign rsp_a_pwm       = a_pwm_ff;
   assign rsp_b_in1       = b_dir_ff[1];
   assign rsp_b_in2       = b_dir_ff[0];
   assign rsp_b_pwm       = b_pwm_ff;
   assign rsp_standby_pin = stby_out_ff;
   assign rsp_duty_a_out  = a_duty_ff;
   assign rsp_duty_b_out  = b_duty_ff;

endmodule

// File: bench/dual_motor_pwm_drive_core_tb.sv
`timescale 1ns / 100ps
module dual_motor_pwm_drive_core_tb;
   import dmpd_pkg::*;

   // One request: opcode plus every payload field
   typedef struct packed {
      logic [2:0]                opcode;
      logic signed [SPEED_W-1:0] speed_a;
      logic signed [SPEED_W-1:0] speed_b;
      logic                      standby;
   } motor_cmd_type;

   // One response: bridge pins and duty readback
   typedef struct packed {
      logic              a_in1;
      logic              a_in2;
      logic              a_pwm;
      logic              b_in1;
      logic              b_in2;
      logic              b_pwm;
      logic              standby;
      logic [DUTY_W-1:0] duty_a;
      logic [DUTY_W-1:0] duty_b;
   } bridge_pins_type;

   localparam logic [1:0] REG_SPARE       = 2'd3;   // no register behind it
   localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] OP_UNUSED_MID   = 3'd6;
   localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
   localparam int         DRAIN_CYCLES    = COUNT_WIDTH + 29;
   localparam int         REPORT_LIMIT    = 10;

   // Shadow of the drive: registers, lane state, shared counter; queue of due pin sets
   class bridge_scoreboard;
      logic [CSR_W-1:0]       period_ticks;
      logic [SPEED_W-1:0]     min_frac;
      logic [SPEED_W-1:0]     deadband;
      logic [DUTY_W-1:0]      duty_a, duty_b;
      logic [COUNT_WIDTH-1:0] on_a, on_b, counter;
      logic [1:0]             dir_a, dir_b;
      logic                   stby;
      bridge_pins_type        pins_due[$];
      int                     errors;
      int                     checked;
      int                     op_count[8];

      function new();
         period_ticks = 20'd1000;
         min_frac = '0;
         deadband = '0;
         duty_a = '0;
         duty_b = '0;
         on_a = '0;
         on_b = '0;
         counter = '0;
         dir_a = DIR_COAST;
         dir_b = DIR_COAST;
         stby = 1'b0;
         errors = 0;
         checked = 0;
         foreach (op_count[i]) op_count[i] = 0;
      endfunction

      // A zero period behaves as a period of one
      function longint unsigned live_period();
         longint unsigned p;
         p = 64'(period_ticks);
         return (p == 0) ? 1 : p;
      endfunction

      function void update_on_ticks();
         longint unsigned p;
         p = live_period();
         on_a = COUNT_WIDTH'((p * 64'(duty_a)) / 255);
         on_b = COUNT_WIDTH'((p * 64'(duty_b)) / 255);
      endfunction

      // Speed command to direction and duty; fractions above one saturate
      function void set_lane(input logic [SPEED_W-1:0] raw, output logic [1:0] dir,
                             output logic [DUTY_W-1:0] duty);
         longint unsigned mag, db, mf, eff, scaled;
         mag = 64'(raw);
         if (raw[SPEED_W-1]) mag = 65536 - mag;
         db = 64'((deadband > Q_ONE) ? Q_ONE : deadband);
         mf = 64'((min_frac > Q_ONE) ? Q_ONE : min_frac);
         if (mag < db) mag = 0;
         if (mag == 0) begin
            dir = DIR_COAST;
            duty = '0;
         end else begin
            dir = raw[SPEED_W-1] ? DIR_REV : DIR_FWD;
            eff = mf * 32768 + (32768 - mf) * mag;
            scaled = (eff * 255) >> 30;
            duty = (scaled > 255) ? DUTY_MAX : scaled[DUTY_W-1:0];
         end
      endfunction

      function void write_register(input logic [1:0] idx, input logic [CSR_W-1:0] value);
         case (idx)
            REG_PERIOD: begin
               period_ticks = value;
               update_on_ticks();
            end
            REG_MIN_FRAC: min_frac = value[SPEED_W-1:0];
            REG_DEADBAND: deadband = value[SPEED_W-1:0];
            default: ;
         endcase
      endfunction

      // Accepted request: advance the shadow and queue the pins it must produce
      function void note_command(input motor_cmd_type c);
         logic [COUNT_WIDTH-1:0] nxt;
         bridge_pins_type        want;
         op_count[c.opcode]++;
         case (c.opcode)
            OP_TICK: begin
               nxt = counter + 1'b1;
               counter = (nxt >= live_period()) ? '0 : nxt;
            end
            OP_SET_A: set_lane(c.speed_a, dir_a, duty_a);
            OP_SET_B: set_lane(c.speed_b, dir_b, duty_b);
            OP_SET_AB: begin
               set_lane(c.speed_a, dir_a, duty_a);
               set_lane(c.speed_b, dir_b, duty_b);
            end
            OP_STANDBY: stby = c.standby;
            default: ;
         endcase
         update_on_ticks();
         want.a_in1 = dir_a[1];
         want.a_in2 = dir_a[0];
         want.a_pwm = counter < on_a;
         want.b_in1 = dir_b[1];
         want.b_in2 = dir_b[0];
         want.b_pwm = counter < on_b;
         want.standby = stby;
         want.duty_a = duty_a;
         want.duty_b = duty_b;
         pins_due.push_back(want);
      endfunction

      function string pins_text(input bridge_pins_type p);
         return $sformatf("A in %b%b pwm %b duty %0d | B in %b%b pwm %b duty %0d | stby %b",
                          p.a_in1, p.a_in2, p.a_pwm, p.duty_a,
                          p.b_in1, p.b_in2, p.b_pwm, p.duty_b, p.standby);
      endfunction

      // Accepted response against the oldest due pin set
      function void check_pins(input bridge_pins_type got);
         bridge_pins_type want;
         if (pins_due.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: response with nothing outstanding: %s", $time, pins_text(got));
            return;
         end
         want = pins_due.pop_front();
         checked++;
         if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("%0t: response %0d mismatch", $time, checked);
               $display("   expected %s", pins_text(want));
               $display("   actual   %s", pins_text(got));
            end
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [2:0]                req_opcode = OP_TICK;
   logic signed [SPEED_W-1:0] req_speed_a = '0;
   logic signed [SPEED_W-1:0] req_speed_b = '0;
   logic                      req_standby_enable = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_a_in1, rsp_a_in2, rsp_a_pwm;
   logic                      rsp_b_in1, rsp_b_in2, rsp_b_pwm;
   logic                      rsp_standby_pin;
   logic [DUTY_W-1:0]         rsp_duty_a_out, rsp_duty_b_out;
   logic                      csr_we = 1'b0;
   logic [1:0]                csr_index = REG_PERIOD;
   logic [CSR_W-1:0]          csr_wdata = '0;

   bit                        quiet = 1'b0;   // no idling on either side
   int                        settings_used = 1;
   bridge_scoreboard          pin_board = new();

   dual_motor_pwm_drive_core i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = int'($urandom_range(0, 99));
      if (quiet || r < 60) return 0;
      if (r < 92) return int'($urandom_range(1, 3));
      if (r < 98) return int'($urandom_range(4, 12));
      return int'($urandom_range(20, 40));
   endfunction

   // Speed mix: extremes, values around zero and around the deadband, anything
   function automatic logic signed [SPEED_W-1:0] pick_speed(input logic [SPEED_W-1:0] db);
      logic [SPEED_W-1:0] near;
      near = db + SPEED_W'($urandom_range(0, 4) - 2);
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return '0;
         3: return SPEED_W'($urandom_range(0, 6) - 3);
         4: return $urandom_range(0, 1) ? near : -near;
         default: return SPEED_W'($urandom);
      endcase
   endfunction

   // Request side: hold valid and payload until the transaction is taken
   task automatic send_command(input motor_cmd_type c);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= c.opcode;
      req_speed_a <= c.speed_a;
      req_speed_b <= c.speed_b;
      req_standby_enable <= c.standby;
      do @(posedge clock); while (!req_ready);
      pin_board.note_command(c);
   endtask

   // Wait for every response, then let the block settle
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pin_board.pins_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Back-to-back writes to all indexes; junk above the fraction fields and at the spare index
   task automatic apply_settings(input logic [CSR_W-1:0] period,
                                 input logic [SPEED_W-1:0] frac, input logic [SPEED_W-1:0] db);
      logic [CSR_W-1:0] value [4];
      value[REG_PERIOD] = period;
      value[REG_MIN_FRAC] = CSR_W'($urandom);
      value[REG_MIN_FRAC][SPEED_W-1:0] = frac;
      value[REG_DEADBAND] = CSR_W'($urandom);
      value[REG_DEADBAND][SPEED_W-1:0] = db;
      value[REG_SPARE] = CSR_W'($urandom);
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= 2'(i);
         csr_wdata <= value[i];
         @(posedge clock);
         pin_board.write_register(2'(i), value[i]);
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic run_random(input int count);
      motor_cmd_type c;
      int            r;
      repeat (count) begin
         r = int'($urandom_range(0, 99));
         if (r < 45) c.opcode = OP_TICK;
         else if (r < 60) c.opcode = OP_SET_A;
         else if (r < 72) c.opcode = OP_SET_B;
         else if (r < 85) c.opcode = OP_SET_AB;
         else if (r < 94) c.opcode = OP_STANDBY;
         else c.opcode = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
         c.speed_a = pick_speed(pin_board.deadband);
         c.speed_b = pick_speed(pin_board.deadband);
         c.standby = 1'($urandom_range(0, 1));
         send_command(c);
      end
   endtask

   // Response side: random back-pressure, check every accepted transaction
   always @(posedge clock) begin : response_sink
      int hold;
      if (reset) begin
         hold = 0;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            pin_board.check_pins(bridge_pins_type'{rsp_a_in1, rsp_a_in2, rsp_a_pwm,
                                                   rsp_b_in1, rsp_b_in2, rsp_b_pwm,
                                                   rsp_standby_pin,
                                                   rsp_duty_a_out, rsp_duty_b_out});
         if (hold == 0 && $urandom_range(0, 3) == 0) hold = pick_gap();
         rsp_ready <= (hold == 0);
         if (hold > 0) hold--;
      end
   end

   initial begin : stimulus
      logic [CSR_W-1:0]   period_pick;
      logic [SPEED_W-1:0] frac_pick, db_pick;
      int                 r;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: lane extremes, coast, every opcode, standby toggles
      send_command(motor_cmd_type'{OP_TICK, 16'h0000, 16'h0000, 1'b0});
      send_command(motor_cmd_type'{OP_SET_A, 16'h7FFF, 16'h0000, 1'b0});
      send_command(motor_cmd_type'{OP_SET_B, 16'h1234, 16'h8000, 1'b1});
      send_command(motor_cmd_type'{OP_TICK, 16'hFFFF, 16'hFFFF, 1'b1});
      send_command(motor_cmd_type'{OP_SET_AB, 16'h0001, 16'hFFFF, 1'b0});
      send_command(motor_cmd_type'{OP_SET_AB, 16'h0000, 16'h0000, 1'b0});
      send_command(motor_cmd_type'{OP_SET_A, 16'h8001, 16'h7FFF, 1'b0});
      send_command(motor_cmd_type'{OP_SET_B, 16'h0000, 16'h4000, 1'b0});
      send_command(motor_cmd_type'{OP_STANDBY, 16'h0000, 16'h0000, 1'b1});
      send_command(motor_cmd_type'{OP_TICK, 16'h0000, 16'h0000, 1'b0});
      send_command(motor_cmd_type'{OP_STANDBY, 16'hFFFF, 16'hFFFF, 1'b0});
      send_command(motor_cmd_type'{OP_STANDBY, 16'h5555, 16'hAAAA, 1'b1});
      send_command(motor_cmd_type'{OP_UNUSED_FIRST, 16'h8000, 16'h7FFF, 1'b0});
      send_command(motor_cmd_type'{OP_UNUSED_MID, 16'h0000, 16'h0000, 1'b0});
      send_command(motor_cmd_type'{OP_UNUSED_LAST, 16'hAAAA, 16'h5555, 1'b0});
      send_command(motor_cmd_type'{OP_TICK, 16'h0000, 16'h0000, 1'b0});
      send_command(motor_cmd_type'{OP_SET_AB, 16'h8000, 16'h7FFF, 1'b0});
      send_command(motor_cmd_type'{OP_TICK, 16'h0000, 16'h0000, 1'b0});
      drain_pipeline();

      // Zero period acts as one; minimum fraction above one saturates
      apply_settings(20'd0, 16'hFFFF, 16'h0000);
      run_random(100);
      drain_pipeline();

      // Widest period; deadband saturated, so only full negative speed survives it
      apply_settings(20'hFFFFF, 16'h0000, 16'hFFFF);
      send_command(motor_cmd_type'{OP_SET_AB, 16'h8000, 16'h7FFF, 1'b0});
      send_command(motor_cmd_type'{OP_SET_AB, 16'h7FFF, 16'h8001, 1'b0});
      send_command(motor_cmd_type'{OP_TICK, 16'h0000, 16'h0000, 1'b0});
      run_random(100);
      drain_pipeline();

      // Period of one after a long one: counter must recover; fractions exactly one
      apply_settings(20'd1, Q_ONE, Q_ONE);
      run_random(100);
      drain_pipeline();

      // Short period, moderate floor and deadband, no idling at all
      apply_settings(20'd5, 16'd8000, 16'd300);
      quiet = 1'b1;
      run_random(100);
      quiet = 1'b0;

      // Random settings, mostly short periods so the PWM pins toggle often
      for (int k = 0; k < 7; k++) begin
         drain_pipeline();
         r = int'($urandom_range(0, 9));
         if (r < 7) period_pick = CSR_W'($urandom_range(1, 40));
         else if (r == 7) period_pick = CSR_W'($urandom_range(41, 2000));
         else if (r == 8) period_pick = '0;
         else period_pick = CSR_W'($urandom);
         frac_pick = SPEED_W'($urandom_range(0, 36000));
         db_pick = ($urandom_range(0, 3) == 0) ? SPEED_W'($urandom_range(0, 40000))
                                                : SPEED_W'($urandom_range(0, 4000));
         apply_settings(period_pick, frac_pick, db_pick);
         quiet = (k == 3);
         run_random(100);
      end
      quiet = 1'b0;
      drain_pipeline();

      $display("covered %0d register settings: %0d ticks, %0d speed sets, %0d standby, %0d unused",
               settings_used, pin_board.op_count[OP_TICK],
               pin_board.op_count[OP_SET_A] + pin_board.op_count[OP_SET_B]
               + pin_board.op_count[OP_SET_AB],
               pin_board.op_count[OP_STANDBY],
               pin_board.op_count[OP_UNUSED_FIRST] + pin_board.op_count[OP_UNUSED_MID]
               + pin_board.op_count[OP_UNUSED_LAST]);
      $display("%0d responses checked, %0d errors", pin_board.checked, pin_board.errors);
      if (pin_board.errors == 0 && pin_board.pins_due.size() == 0)
         $display("dual_motor_pwm_drive_core_tb OK");
      else
         $display("dual_motor_pwm_drive_core_tb NOT OK");
      $finish;
   end

   // Hard limit, several times the slowest legal run
   initial begin : watchdog
      #3_000_000;
      $display("timed out with %0d responses outstanding", pin_board.pins_due.size());
      $display("dual_motor_pwm_drive_core_tb NOT OK");
      $finish;
   end

endmodule
